// ===== hw/rtl/scc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack calculator package
// Shared types, operation codes, status codes and datapath commands.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = 6;
    localparam int DATA_W      = 64;
    localparam int KIND_W      = 4;
    localparam int OFF_W       = 8;
    localparam int STAT_W      = 3;
    localparam logic [OFF_W-1:0] SLOT_STEP = 8'h4;

    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t K_PUSH  = 4'd0;
    localparam kind_t K_ADD   = 4'd1;
    localparam kind_t K_SUB   = 4'd2;
    localparam kind_t K_MUL   = 4'd3;
    localparam kind_t K_DIV   = 4'd4;
    localparam kind_t K_SQRT  = 4'd5;
    localparam kind_t K_DUP   = 4'd6;
    localparam kind_t K_DROP  = 4'd7;
    localparam kind_t K_SWAP  = 4'd8;
    localparam kind_t K_OVER  = 4'd9;
    localparam kind_t K_ROT   = 4'd10;
    localparam kind_t K_PTOP  = 4'd11;
    localparam kind_t K_PALL  = 4'd12;

    typedef logic [STAT_W-1:0] status_t;
    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_UNDER   = 3'd1;
    localparam status_t ST_OVER    = 3'd2;
    localparam status_t ST_DIVZ    = 3'd3;
    localparam status_t ST_NEGROOT = 3'd4;

    // Selects for the value written back to the stack
    typedef enum logic [2:0] {
        WR_OPND = 3'd0,
        WR_ALU  = 3'd1,
        WR_T    = 3'd2,
        WR_S    = 3'd3,
        WR_U    = 3'd4
    } wsel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             load_in;   // capture input item
        logic             rd_en;     // issue stack read
        logic [PTR_W-1:0] rd_addr;
        logic [1:0]       rd_dst;    // 0 T, 1 S, 2 U
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        wsel_t            wr_sel;
        logic             alu_start; // start multi-cycle unit
        logic             res_load;  // load output register
        logic             res_from_t;// result = captured T else top reg
        logic [OFF_W-1:0] res_off;
        status_t          res_status;
        logic [CNT_W-1:0] res_count;
        logic             res_last;
        logic             top_load;  // refresh cached top from read data
        logic             top_clear;
        logic             top_from_wr;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic  alu_done;
        logic  t_neg;
        logic  s_zero;
        logic  out_busy;
    } stat_t;

endpackage

// ===== hw/rtl/scc_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack calculator stream interfaces
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface scc_op_if;
    logic                       valid;
    logic                       ready;
    logic [scc_pkg::KIND_W-1:0] kind;
    logic signed [63:0]         operand;
    modport source (output valid, kind, operand, input ready);
    modport sink   (input valid, kind, operand, output ready);
endinterface

interface scc_res_if;
    logic                       valid;
    logic                       ready;
    logic signed [63:0]         result_value;
    logic [7:0]                 slot_offset;
    logic [2:0]                 status;
    logic [5:0]                 entries_left;
    logic                       last;
    modport source (output valid, result_value, slot_offset, status, entries_left, last,
                    input ready);
    modport sink   (input valid, result_value, slot_offset, status, entries_left, last,
                    output ready);
endinterface

// ===== hw/rtl/scc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module scc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule

// ===== hw/rtl/scc_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack calculator arithmetic unit
// 32x32-split multiply summing three partial products, bit-serial signed
// divide (64 steps) and bit-serial square root (32 steps); add and sub are done in the datapath.
// ----------------------------------------------------------------------------
module scc_alu (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  scc_pkg::kind_t                kind,
    input  logic [scc_pkg::DATA_W-1:0]    t,
    input  logic [scc_pkg::DATA_W-1:0]    s,
    output logic                          done,
    output logic [scc_pkg::DATA_W-1:0]    result
);
    import scc_pkg::*;

    logic              busy_reg;
    logic [6:0]        cnt_reg;
    kind_t             op_reg;
    logic [63:0]       a_reg, b_reg;     // dividend/radicand, divisor
    logic [63:0]       q_reg;            // quotient or root
    logic [65:0]       r_reg;            // partial remainder
    logic [63:0]       acc_reg;          // multiply accumulator
    logic              neg_reg;
    logic [63:0]       res_reg;
    logic              done_reg;
    logic [63:0]       ppart;
    logic [64:0]       dtrial;
    logic [65:0]       sr_rem, sr_trial;
    logic [63:0]       t_abs, s_abs;

    assign t_abs = t[63] ? (64'd0 - t) : t;
    assign s_abs = s[63] ? (64'd0 - s) : s;

    // One 32x32 partial product per cycle: lo*lo, lo*hi, hi*lo
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    ppart = a_reg[31:0] * b_reg[31:0];
            2'd1:    ppart = {a_reg[31:0] * b_reg[63:32], 32'd0};
            default: ppart = {a_reg[63:32] * b_reg[31:0], 32'd0};
        endcase
    end

    // Restoring divide step and square root step
    assign dtrial   = {r_reg[63:0], a_reg[63]} - {1'b0, b_reg};
    assign sr_rem   = {r_reg[63:0], a_reg[63:62]};
    assign sr_trial = sr_rem - {q_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (((op_reg == K_MUL) && (cnt_reg == 7'd2)) ||
                    ((op_reg != K_MUL) && (cnt_reg == 7'd63)) ||
                    ((op_reg == K_SQRT) && (cnt_reg == 7'd31)))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg  <= kind;
            acc_reg <= '0;
            r_reg   <= '0;
            q_reg   <= '0;
            case (kind)
                K_MUL:
                begin
                    a_reg <= s;
                    b_reg <= t;
                end
                K_DIV:
                begin
                    a_reg   <= t_abs;
                    b_reg   <= s_abs;
                    neg_reg <= t[63] ^ s[63];
                end
                default:
                begin
                    a_reg <= t;
                    b_reg <= s;
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                K_MUL:
                begin
                    acc_reg <= acc_reg + ppart;
                    if (cnt_reg == 7'd2)
                    begin
                        res_reg <= acc_reg + ppart;
                    end
                end
                K_DIV:
                begin
                    a_reg <= {a_reg[62:0], 1'b0};
                    if (!dtrial[64])
                    begin
                        r_reg <= {1'b0, 1'b0, dtrial[63:0]};
                        q_reg <= {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= {2'b00, r_reg[62:0], a_reg[63]};
                        q_reg <= {q_reg[62:0], 1'b0};
                    end
                    if (cnt_reg == 7'd63)
                    begin
                        res_reg <= neg_reg
                            ? (64'd0 - (dtrial[64] ? {q_reg[62:0], 1'b0}
                                                   : {q_reg[62:0], 1'b1}))
                            : (dtrial[64] ? {q_reg[62:0], 1'b0}
                                          : {q_reg[62:0], 1'b1});
                    end
                end
                default:
                begin
                    a_reg <= {a_reg[61:0], 2'b00};
                    if (!sr_trial[65])
                    begin
                        r_reg <= sr_trial;
                        q_reg <= {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= sr_rem;
                        q_reg <= {q_reg[62:0], 1'b0};
                    end
                    if (cnt_reg == 7'd31)
                    begin
                        res_reg <= sr_trial[65] ? {q_reg[62:0], 1'b0}
                                                : {q_reg[62:0], 1'b1};
                    end
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    ap_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy_reg) else $error("alu done while busy");
    ap_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("alu done held");
    ap_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("alu not busy after start");
endmodule

// ===== hw/rtl/scc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack calculator datapath
// Stack RAM, operand registers, ALU and the output register.
// ----------------------------------------------------------------------------
module scc_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  scc_pkg::cmd_t     cmd,
    output scc_pkg::stat_t    stat,
    output scc_pkg::kind_t    kind_q,
    scc_op_if.sink            op,
    scc_res_if.source         res
);
    import scc_pkg::*;

    kind_t             kind_reg;
    logic [63:0]       opnd_reg, t_reg, s_reg, u_reg, top_reg;
    logic [63:0]       rd_data, wr_data, alu_res;
    logic [1:0]        dst_reg;
    logic              rd_pend_reg;
    logic              alu_done;
    logic              ovalid_reg;
    logic [63:0]       oval_reg;
    logic [OFF_W-1:0]  ooff_reg;
    status_t           ostat_reg;
    logic [CNT_W-1:0]  ocnt_reg;
    logic              olast_reg;

    scc_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_data)
    );

    scc_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.alu_start),
        .kind   (kind_reg),
        .t      (t_reg),
        .s      (s_reg),
        .done   (alu_done),
        .result (alu_res)
    );

    // Write-back value select; add and sub are done inline
    always_comb
    begin
        case (cmd.wr_sel)
            WR_OPND: wr_data = opnd_reg;
            WR_ALU:
            begin
                case (kind_reg)
                    K_ADD:   wr_data = s_reg + t_reg;
                    K_SUB:   wr_data = s_reg - t_reg;
                    default: wr_data = alu_res;
                endcase
            end
            WR_T:    wr_data = t_reg;
            WR_S:    wr_data = s_reg;
            WR_U:    wr_data = u_reg;
            default: wr_data = opnd_reg;
        endcase
    end

    // Read pending tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.rd_en;
        end
    end

    // Capture input and operands
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            dst_reg <= cmd.rd_dst;
        end
        if (cmd.load_in)
        begin
            kind_reg <= op.kind;
            opnd_reg <= op.operand;
        end
        if (rd_pend_reg)
        begin
            case (dst_reg)
                2'd0:    t_reg <= rd_data;
                2'd1:    s_reg <= rd_data;
                default: u_reg <= rd_data;
            endcase
        end
    end

    // Cached top of stack, zero while the stack is empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else if (cmd.top_clear)
        begin
            top_reg <= '0;
        end
        else if (cmd.top_from_wr)
        begin
            top_reg <= wr_data;
        end
        else if (cmd.top_load)
        begin
            top_reg <= rd_data;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            oval_reg  <= cmd.res_from_t ? t_reg : top_reg;
            ooff_reg  <= cmd.res_off;
            ostat_reg <= cmd.res_status;
            ocnt_reg  <= cmd.res_count;
            olast_reg <= cmd.res_last;
        end
    end

    assign res.valid        = ovalid_reg;
    assign res.result_value = oval_reg;
    assign res.slot_offset  = ooff_reg;
    assign res.status       = ostat_reg;
    assign res.entries_left = ocnt_reg;
    assign res.last         = olast_reg;

    assign kind_q         = kind_reg;
    assign stat.alu_done  = alu_done;
    assign stat.t_neg     = t_reg[63];
    assign stat.s_zero    = (s_reg == 64'd0);
    assign stat.out_busy  = ovalid_reg && !res.ready;

    ap_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !res.ready) |-> !cmd.res_load)
        else $error("result overwritten while stalled");
    ap_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> !cmd.alu_start) else $error("write during alu start");
    ap_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |-> !cmd.wr_en) else $error("load during write");
endmodule

// ===== hw/rtl/scc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack calculator controller
// Sequences stack reads, ALU runs, write-back and result transfers.
// ----------------------------------------------------------------------------
module scc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    output logic              op_ready,
    input  scc_pkg::kind_t    kind_in,
    input  scc_pkg::kind_t    kind_q,
    input  scc_pkg::stat_t    stat,
    output scc_pkg::cmd_t     cmd
);
    import scc_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD    = 9'b000000010,
        S_WAIT  = 9'b000000100,
        S_EXEC  = 9'b000001000,
        S_ALU   = 9'b000010000,
        S_WB2   = 9'b000100000,
        S_TOP   = 9'b001000000,
        S_EMIT  = 9'b010000000,
        S_DRAIN = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;   // stack depth
    logic [1:0]        rdi_reg, rdi_next;   // reads issued
    logic [OFF_W-1:0]  off_reg, off_next;
    status_t           st_reg, st_next;
    logic              pt_reg, pt_next;     // result is captured top (print)
    logic [1:0]        need;
    logic              accept;
    logic [CNT_W-1:0]  c_m1, c_m2, c_m3;

    assign accept = op_valid && op_ready;
    assign c_m1 = cnt_reg - 6'd1;
    assign c_m2 = cnt_reg - 6'd2;
    assign c_m3 = cnt_reg - 6'd3;

    always_comb
    begin
        case (kind_q)
            K_ADD, K_SUB, K_MUL, K_DIV, K_SWAP, K_OVER: need = 2'd2;
            K_ROT:                                     need = 2'd3;
            K_SQRT, K_DUP, K_DROP, K_PTOP:             need = 2'd1;
            default:                                   need = 2'd0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rdi_next   = rdi_reg;
        off_next   = off_reg;
        st_next    = st_reg;
        pt_next    = pt_reg;
        op_ready   = 1'b0;
        cmd        = '0;
        cmd.wr_sel = WR_OPND;
        case (state_reg)
            S_IDLE:
            begin
                op_ready = 1'b1;
                if (accept)
                begin
                    cmd.load_in = 1'b1;
                    rdi_next    = '0;
                    off_next    = '0;
                    st_next     = ST_OK;
                    pt_next     = 1'b0;
                    state_next  = (kind_in == K_PALL) ? S_DRAIN : S_RD;
                end
            end
            // Fetch up to three top entries
            S_RD:
            begin
                if ({4'd0, need} > cnt_reg)
                begin
                    st_next    = ST_UNDER;
                    state_next = S_EMIT;
                end
                else if (rdi_reg == need)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_dst  = rdi_reg;
                    cmd.rd_addr = (rdi_reg == 2'd0) ? c_m1[PTR_W-1:0] :
                                  (rdi_reg == 2'd1) ? c_m2[PTR_W-1:0] : c_m3[PTR_W-1:0];
                    rdi_next    = rdi_reg + 2'd1;
                end
            end
            S_WAIT:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_TOP;
                case (kind_q)
                    K_PUSH, K_DUP:
                    begin
                        if (cnt_reg >= 6'(STACK_DEPTH))
                        begin
                            st_next    = ST_OVER;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.wr_en       = 1'b1;
                            cmd.wr_addr     = cnt_reg[PTR_W-1:0];
                            cmd.wr_sel      = (kind_q == K_PUSH) ? WR_OPND : WR_T;
                            cmd.top_from_wr = 1'b1;
                            cnt_next        = cnt_reg + 6'd1;
                            state_next      = S_EMIT;
                        end
                    end
                    K_ADD, K_SUB:
                    begin
                        cmd.wr_en       = 1'b1;
                        cmd.wr_addr     = c_m2[PTR_W-1:0];
                        cmd.wr_sel      = WR_ALU;
                        cmd.top_from_wr = 1'b1;
                        cnt_next        = c_m1;
                        state_next      = S_EMIT;
                    end
                    K_MUL, K_DIV, K_SQRT:
                    begin
                        if ((kind_q == K_DIV) && stat.s_zero)
                        begin
                            st_next    = ST_DIVZ;
                            state_next = S_EMIT;
                        end
                        else if ((kind_q == K_SQRT) && stat.t_neg)
                        begin
                            st_next    = ST_NEGROOT;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.alu_start = 1'b1;
                            state_next    = S_ALU;
                        end
                    end
                    K_DROP:
                    begin
                        cnt_next = c_m1;
                        if (c_m1 == 6'd0)
                        begin
                            cmd.top_clear = 1'b1;
                            state_next    = S_EMIT;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_dst  = 2'd2;
                            cmd.rd_addr = c_m2[PTR_W-1:0];
                        end
                    end
                    K_PTOP:
                    begin
                        cnt_next = c_m1;
                        pt_next  = 1'b1;
                        if (c_m1 == 6'd0)
                        begin
                            cmd.top_clear = 1'b1;
                            state_next    = S_EMIT;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_dst  = 2'd2;
                            cmd.rd_addr = c_m2[PTR_W-1:0];
                        end
                    end
                    K_SWAP, K_OVER:
                    begin
                        cmd.wr_en       = 1'b1;
                        cmd.wr_addr     = c_m1[PTR_W-1:0];
                        cmd.wr_sel      = WR_S;
                        cmd.top_from_wr = 1'b1;
                        state_next      = (kind_q == K_SWAP) ? S_WB2 : S_EMIT;
                    end
                    K_ROT:
                    begin
                        cmd.wr_en       = 1'b1;
                        cmd.wr_addr     = c_m1[PTR_W-1:0];
                        cmd.wr_sel      = WR_U;
                        cmd.top_from_wr = 1'b1;
                        state_next      = S_WB2;
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_ALU:
            begin
                if (stat.alu_done)
                begin
                    cmd.wr_en       = 1'b1;
                    cmd.wr_sel      = WR_ALU;
                    cmd.top_from_wr = 1'b1;
                    if (kind_q == K_SQRT)
                    begin
                        cmd.wr_addr = c_m1[PTR_W-1:0];
                    end
                    else
                    begin
                        cmd.wr_addr = c_m2[PTR_W-1:0];
                        cnt_next    = c_m1;
                    end
                    state_next = S_EMIT;
                end
            end
            // Second write of swap and rot
            S_WB2:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_T;
                cmd.wr_addr = (kind_q == K_SWAP) ? c_m2[PTR_W-1:0] : c_m3[PTR_W-1:0];
                state_next  = S_EMIT;
            end
            // Read data for the new top arrives
            S_TOP:
            begin
                cmd.top_load = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_from_t = pt_reg;
                    cmd.res_status = st_reg;
                    cmd.res_count  = cnt_reg;
                    cmd.res_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            // Pop and emit one entry per pass
            S_DRAIN:
            begin
                if (cnt_reg == 6'd0)
                begin
                    cmd.top_clear = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (rdi_reg == 2'd0)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_dst  = 2'd0;
                    cmd.rd_addr = c_m1[PTR_W-1:0];
                    rdi_next    = 2'd1;
                end
                else if (rdi_reg == 2'd1)
                begin
                    rdi_next = 2'd2;
                end
                else if (!stat.out_busy)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_from_t = 1'b1;
                    cmd.res_off    = off_reg;
                    cmd.res_status = ST_OK;
                    cmd.res_count  = c_m1;
                    cmd.res_last   = (c_m1 == 6'd0);
                    cnt_next       = c_m1;
                    off_next       = off_reg + SLOT_STEP;
                    rdi_next       = 2'd0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rdi_reg   <= '0;
            off_reg   <= '0;
            st_reg    <= ST_OK;
            pt_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rdi_reg   <= rdi_next;
            off_reg   <= off_next;
            st_reg    <= st_next;
            pt_reg    <= pt_next;
        end
    end

    ap_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 6'(STACK_DEPTH)) else $error("depth beyond stack size");
    ap_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    ap_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && st_reg != ST_OK) |-> !cmd.wr_en)
        else $error("write on error");
endmodule

// ===== hw/rtl/stack_calculator_core_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack calculator core, top level
// One stack operation per transfer on op, results on res.
// ----------------------------------------------------------------------------
// One item at a time: no new op is taken until the last one is through.
// The stack RAM gives one read per cycle. Multiply sums three 32x32
// partial products; divide and square root run in the bit-serial unit in
// the ALU. print_all pops and emits one entry per pass through the single
// read port. A stalled result holds the controller until res accepts it.
// The stack lives in a 32x64 RAM with registered read; the top entry is
// cached.
module stack_calculator_core_top (
    input  logic       clk,
    input  logic       rst_n,
    scc_op_if.sink     op,
    scc_res_if.source  res
);
    import scc_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    kind_t kind_q;

    scc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (op.valid),
        .op_ready (op.ready),
        .kind_in  (op.kind),
        .kind_q   (kind_q),
        .stat     (stat),
        .cmd      (cmd)
    );

    scc_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .kind_q (kind_q),
        .op     (op),
        .res    (res)
    );
endmodule
